// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, reset masks the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PPR_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/ppr_pkg.sv -----
package ppr_pkg;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } pat_t;

  typedef struct packed {
    logic [4:0] channel_index;
    logic [7:0] note_byte;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect_code;
    logic [7:0] effect_info;
    logic       last;
  } row_t;

  typedef struct packed {
    logic [7:0] note_byte;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect_code;
    logic [7:0] effect_info;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{
    note_byte:   8'hff,
    instrument:  8'h00,
    volume:      8'hff,
    effect_code: 8'hff,
    effect_info: 8'h00
  };

endpackage

// ----- sv/packed_pattern_row_decoder.sv -----
// Channel  Direction  Handshake            Payload
// pat      in         pat_valid/pat_ready  ppr_pkg::pat_t (command, data_byte)
// row      out        row_valid/row_ready  ppr_pkg::row_t (one channel entry)
// cfg      in         cfg_we               cfg_wdata = channel_count
//
// A field byte reads the row store entry, then merges and writes it back in S_RMW
// when its channel is below MAX_CHANNELS. Channel bytes, skipped header bytes,
// pattern starts and ignored codes are handled within S_IDLE. A row end or an empty
// row emits each channel through S_RD then S_LD, paced by the store's read port and
// held while row_ready stays low; pat_ready is low until the last beat is registered.
// Reset is synchronous; row store entries carry valid bits instead of being cleared.
`include "assert_macros.svh"

module packed_pattern_row_decoder #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pat_valid,
  output logic          pat_ready,
  input  ppr_pkg::pat_t pat,
  output logic          row_valid,
  input  logic          row_ready,
  output ppr_pkg::row_t row,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_wdata
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [5:0] MAXC = 6'(MAX_CHANNELS);
  localparam int EW = $bits(ppr_pkg::entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RMW  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_LD   = 2'd3;

  localparam logic [2:0] PH_CHAN = 3'd0;
  localparam logic [2:0] PH_NOTE = 3'd1;
  localparam logic [2:0] PH_INST = 3'd2;
  localparam logic [2:0] PH_VOL  = 3'd3;
  localparam logic [2:0] PH_CMD  = 3'd4;
  localparam logic [2:0] PH_INFO = 3'd5;

  localparam logic [2:0] SL_NOTE = 3'd0;
  localparam logic [2:0] SL_INST = 3'd1;
  localparam logic [2:0] SL_VOL  = 3'd2;
  localparam logic [2:0] SL_CMD  = 3'd3;
  localparam logic [2:0] SL_INFO = 3'd4;

  logic [1:0]              state;
  logic [2:0]              phase;
  logic [2:0]              pending;
  logic [1:0]              hskip;
  logic [4:0]              cur;
  logic [5:0]              chan_cnt;
  logic [MAX_CHANNELS-1:0] vld;
  logic [AW-1:0]           k;
  logic [2:0]              slot;
  logic [7:0]              wbyte;

  logic [AW-1:0]           cur_a;
  logic                    chan_ok;
  logic [5:0]              act_n;
  logic                    last_k;
  logic                    load;
  logic                    we;
  logic [AW-1:0]           raddr;
  logic [EW-1:0]           rdata;
  ppr_pkg::entry_t         rd_entry;
  ppr_pkg::entry_t         old_entry;
  ppr_pkg::entry_t         merged;
  logic [5:0]              adv;

  function automatic logic [5:0] advance(input logic [2:0] pend);
    logic [5:0] r;
    if (pend[0]) begin
      r = {PH_NOTE, pend & 3'b110};
    end else if (pend[1]) begin
      r = {PH_VOL, pend & 3'b100};
    end else if (pend[2]) begin
      r = {PH_CMD, 3'b000};
    end else begin
      r = {PH_CHAN, 3'b000};
    end
    return r;
  endfunction

  assign cur_a     = cur[AW-1:0];
  assign chan_ok   = {1'b0, cur} < MAXC;
  assign pat_ready = (state == S_IDLE);
  assign we        = (state == S_RMW);
  assign raddr     = (state == S_IDLE || state == S_RMW) ? cur_a : k;
  assign load      = (state == S_LD) && (!row_valid || row_ready);
  assign last_k    = (6'(k) + 6'd1) == act_n;
  assign adv       = advance(pending);

  always_comb begin
    if (chan_cnt == 6'd0) begin
      act_n = 6'd1;
    end else if (chan_cnt > MAXC) begin
      act_n = MAXC;
    end else begin
      act_n = chan_cnt;
    end
  end

  always_comb begin
    rd_entry  = vld[k] ? ppr_pkg::entry_t'(rdata) : ppr_pkg::EMPTY_ENTRY;
    old_entry = vld[cur_a] ? ppr_pkg::entry_t'(rdata) : ppr_pkg::EMPTY_ENTRY;
    merged    = old_entry;
    case (slot)
      SL_NOTE: merged.note_byte   = wbyte;
      SL_INST: merged.instrument  = wbyte;
      SL_VOL:  merged.volume      = wbyte;
      SL_CMD:  merged.effect_code = wbyte;
      SL_INFO: merged.effect_info = wbyte;
      default: merged = old_entry;
    endcase
  end

  ppr_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(cur_a),
    .wdata(merged),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_CHAN;
      pending   <= 3'd0;
      hskip     <= 2'd0;
      cur       <= 5'd0;
      chan_cnt  <= 6'd32;
      vld       <= '0;
      k         <= '0;
      row_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        chan_cnt <= cfg_wdata;
      end
      if (load) begin
        row_valid <= 1'b1;
      end else if (row_ready) begin
        row_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pat_valid) begin
            case (pat.command)
              ppr_pkg::CMD_START: begin
                vld     <= '0;
                phase   <= PH_CHAN;
                pending <= 3'd0;
                hskip   <= 2'd2;
              end
              ppr_pkg::CMD_EMPTY: begin
                vld     <= '0;
                phase   <= PH_CHAN;
                pending <= 3'd0;
                hskip   <= 2'd0;
                k       <= '0;
                state   <= S_RD;
              end
              ppr_pkg::CMD_DATA: begin
                wbyte <= pat.data_byte;
                if (hskip != 2'd0) begin
                  hskip <= hskip - 2'd1;
                end else begin
                  case (phase)
                    PH_NOTE: begin
                      slot  <= SL_NOTE;
                      phase <= PH_INST;
                      if (chan_ok) state <= S_RMW;
                    end
                    PH_INST: begin
                      slot               <= SL_INST;
                      {phase, pending}   <= adv;
                      if (chan_ok) state <= S_RMW;
                    end
                    PH_VOL: begin
                      slot               <= SL_VOL;
                      {phase, pending}   <= adv;
                      if (chan_ok) state <= S_RMW;
                    end
                    PH_CMD: begin
                      slot  <= SL_CMD;
                      phase <= PH_INFO;
                      if (chan_ok) state <= S_RMW;
                    end
                    PH_INFO: begin
                      slot               <= SL_INFO;
                      {phase, pending}   <= adv;
                      if (chan_ok) state <= S_RMW;
                    end
                    default: begin
                      if (pat.data_byte == 8'd0) begin
                        phase   <= PH_CHAN;
                        pending <= 3'd0;
                        k       <= '0;
                        state   <= S_RD;
                      end else begin
                        cur              <= pat.data_byte[4:0];
                        {phase, pending} <= advance(pat.data_byte[7:5]);
                      end
                    end
                  endcase
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RMW: begin
          vld[cur_a] <= 1'b1;
          state      <= S_IDLE;
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (load) begin
            if (last_k) begin
              vld   <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row.channel_index <= 5'(k);
      row.note_byte     <= rd_entry.note_byte;
      row.instrument    <= rd_entry.instrument;
      row.volume        <= rd_entry.volume;
      row.effect_code   <= rd_entry.effect_code;
      row.effect_info   <= rd_entry.effect_info;
      row.last          <= last_k;
    end
  end

  `PPR_ASSERT_NEXT(a_rmw_one_cycle, clk, rst, state == S_RMW, state == S_IDLE)
  `PPR_ASSERT_NEXT(a_store_cleared_after_row, clk, rst, load && last_k, vld == '0 && row_valid)
  `PPR_ASSERT(a_emit_index_in_range, clk, rst, state == S_RD || state == S_LD, 6'(k) < act_n)

endmodule

// ----- sv/ppr_ram.sv -----
module ppr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
